// ===== hw/rtl/u16550_pkg.sv =====
// Shared types and constants for the 16550-style UART register file.
// No dependencies; every other RTL file of the block imports this package.
package u16550_pkg;

  // Input action codes
  localparam logic [1:0] ACT_READ   = 2'd0;
  localparam logic [1:0] ACT_WRITE  = 2'd1;
  localparam logic [1:0] ACT_ARRIVE = 2'd2;

  // Register offsets
  localparam logic [2:0] REG_DATA = 3'd0;  // RBR/THR, DLL when DLAB
  localparam logic [2:0] REG_IER  = 3'd1;  // IER, DLM when DLAB
  localparam logic [2:0] REG_IIR  = 3'd2;  // IIR on read, FCR on write
  localparam logic [2:0] REG_LCR  = 3'd3;
  localparam logic [2:0] REG_MCR  = 3'd4;
  localparam logic [2:0] REG_LSR  = 3'd5;  // LSR, prescaler when DLAB
  localparam logic [2:0] REG_MSR  = 3'd6;
  localparam logic [2:0] REG_SCR  = 3'd7;

  localparam logic [7:0] FCR_MASK      = 8'b1100_0111;
  localparam logic [7:0] LCR_RESET     = 8'h03;
  localparam logic [3:0] IIR_RX_AVAIL  = 4'b0100;
  localparam logic [3:0] IIR_THR_EMPTY = 4'b0010;
  localparam logic [3:0] IIR_NONE      = 4'b0001;
  localparam logic [1:0] IIR_FIFO_ON   = 2'b11;
  localparam logic [7:0] LSR_TX_IDLE   = 8'h60;
  localparam int         LCR_DLAB_BIT  = 7;

  // Operation class handed from the front to the back
  typedef enum logic [1:0] {
    OP_NOP,
    OP_READ,
    OP_WRITE,
    OP_PUSH
  } op_kind_t;

  typedef struct packed {
    logic [1:0] action;
    logic [2:0] reg_addr;
    logic [7:0] write_data;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       irq_pending;
    logic       rx_overflow;
  } out_item_t;

  typedef struct packed {
    op_kind_t   kind;
    logic [2:0] addr;
    logic [7:0] data;
  } op_entry_t;

endpackage

// ===== hw/rtl/uart_16550_register_model.sv =====
// Top level of the 16550-style UART register file.
// Depends on u16550_pkg, u16550_front and u16550_back.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------
//  in_     | input     | in_valid/in_stall  | u16550_pkg::in_item_t
//  out_    | output    | out_valid/out_stall| u16550_pkg::out_item_t
//
// One beat per cycle sustained while out_stall is low; each beat yields
// exactly one result beat. An accepted beat is written into the 2-entry
// front queue, and the back then executes it into the result register,
// which drives out_valid and out_item.
// The back executes a beat only when the result register is free or being
// drained, so an output stall holds the back and, once the queue fills,
// raises in_stall. Reset (rst_n low, synchronous) empties the queue,
// clears the result valid flag and loads the register reset values; the
// receive store itself is not cleared and needs no clearing pass.
module uart_16550_register_model #(
  parameter int RX_FIFO_DEPTH = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  u16550_pkg::in_item_t  in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output u16550_pkg::out_item_t out_item
);
  import u16550_pkg::*;

  logic      q_valid;
  logic      q_pop;
  op_entry_t q_entry;

  // Accept and classify beats, hold up to two ahead of execution.
  u16550_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_entry  (q_entry),
    .q_pop    (q_pop)
  );

  // Execute against the register file and receive FIFO, register the result.
  u16550_back #(
    .RX_FIFO_DEPTH (RX_FIFO_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

// ===== hw/rtl/u16550_front.sv =====
// Front end: accepts input beats, classifies them and queues them (2 entries).
// Depends on u16550_pkg.
module u16550_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  u16550_pkg::in_item_t  in_item,
  output logic                  q_valid,
  output u16550_pkg::op_entry_t q_entry,
  input  logic                  q_pop
);
  import u16550_pkg::*;

  localparam int QDEPTH = 2;

  op_entry_t   q_mem_r [QDEPTH];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        push;
  op_entry_t   dec;

  // Classify the beat; the back never looks at the raw action code.
  always_comb begin
    dec.addr = in_item.reg_addr;
    dec.data = in_item.write_data;
    unique case (in_item.action)
      ACT_READ:   dec.kind = OP_READ;
      ACT_WRITE:  dec.kind = OP_WRITE;
      ACT_ARRIVE: begin
        dec.kind = OP_PUSH;
        dec.data = in_item.rx_byte;
      end
      default:    dec.kind = OP_NOP;
    endcase
  end

  assign in_stall = (cnt_r == 2'(QDEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_entry  = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push  ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= dec;
    end
  end

`ifndef SYNTH
  a_q_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");
`endif

endmodule

// ===== hw/rtl/u16550_back.sv =====
// Back end: register file, receive FIFO and result register.
// Depends on u16550_pkg; fed by u16550_front.
module u16550_back #(
  parameter int RX_FIFO_DEPTH = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  u16550_pkg::op_entry_t q_entry,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output u16550_pkg::out_item_t out_item
);
  import u16550_pkg::*;

  localparam int AW = (RX_FIFO_DEPTH > 1) ? $clog2(RX_FIFO_DEPTH) : 1;
  localparam int CW = $clog2(RX_FIFO_DEPTH + 1);

  logic [3:0]    ier_r, ier_nxt;
  logic [7:0]    fcr_r, fcr_nxt;
  logic [7:0]    lcr_r, lcr_nxt;
  logic [3:0]    mcr_r, mcr_nxt;
  logic [7:0]    scr_r, scr_nxt;
  logic [7:0]    dll_r, dll_nxt;
  logic [7:0]    dlm_r, dlm_nxt;
  logic [3:0]    psd_r, psd_nxt;
  logic          iir_seen_r, iir_seen_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [7:0]    rx_mem [RX_FIFO_DEPTH];
  logic [7:0]    head_data_r;
  logic          out_valid_r;
  out_item_t     out_item_r;
  out_item_t     res;
  logic          fire, push, pop, dlab, rx_full, rx_ready;
  logic [7:0]    ident;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(RX_FIFO_DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  assign fire     = q_valid && (!out_valid_r || !out_stall);
  assign q_pop    = fire;
  assign dlab     = lcr_r[LCR_DLAB_BIT];
  assign rx_ready = (cnt_r != '0);
  assign rx_full  = (cnt_r == CW'(RX_FIFO_DEPTH));

  always_comb begin
    ident = {(fcr_r[0] ? IIR_FIFO_ON : 2'b00), 2'b00, IIR_NONE};
    if (rx_ready && ier_r[0]) begin
      ident[3:0] = IIR_RX_AVAIL;
    end else if (ier_r[1] && !iir_seen_r) begin
      ident[3:0] = IIR_THR_EMPTY;
    end
  end

  always_comb begin
    ier_nxt      = ier_r;
    fcr_nxt      = fcr_r;
    lcr_nxt      = lcr_r;
    mcr_nxt      = mcr_r;
    scr_nxt      = scr_r;
    dll_nxt      = dll_r;
    dlm_nxt      = dlm_r;
    psd_nxt      = psd_r;
    iir_seen_nxt = iir_seen_r;
    push         = 1'b0;
    pop          = 1'b0;
    res          = '0;
    unique case (q_entry.kind)
      OP_READ: begin
        unique case (q_entry.addr)
          REG_DATA: begin
            if (dlab) begin
              res.read_data = dll_r;
            end else if (rx_ready) begin
              res.read_data = head_data_r;
              pop           = 1'b1;
            end
          end
          REG_IER:  res.read_data = dlab ? dlm_r : {4'b0, ier_r};
          REG_IIR: begin
            res.read_data = ident;
            iir_seen_nxt  = 1'b1;
          end
          REG_LCR:  res.read_data = lcr_r;
          REG_MCR:  res.read_data = {4'b0, mcr_r};
          REG_LSR:  res.read_data = dlab ? 8'h00 : (LSR_TX_IDLE | {7'b0, rx_ready});
          REG_MSR:  res.read_data = 8'h00;
          REG_SCR:  res.read_data = scr_r;
          default:  res.read_data = 8'h00;
        endcase
      end
      OP_WRITE: begin
        unique case (q_entry.addr)
          REG_DATA: begin
            if (dlab) begin
              dll_nxt = q_entry.data;
            end else begin
              iir_seen_nxt = 1'b0;
              res.tx_valid = 1'b1;
              res.tx_byte  = q_entry.data;
            end
          end
          REG_IER: begin
            if (dlab) dlm_nxt = q_entry.data;
            else      ier_nxt = q_entry.data[3:0];
          end
          REG_IIR:  fcr_nxt = q_entry.data & FCR_MASK;
          REG_LCR:  lcr_nxt = q_entry.data;
          REG_MCR:  mcr_nxt = q_entry.data[3:0];
          REG_LSR: begin
            if (dlab) psd_nxt = q_entry.data[3:0];
          end
          REG_MSR:  ;
          REG_SCR:  scr_nxt = q_entry.data;
          default:  ;
        endcase
      end
      OP_PUSH: begin
        if (rx_full) res.rx_overflow = 1'b1;
        else         push = 1'b1;
      end
      default: ;
    endcase

    head_nxt = pop  ? ptr_inc(head_r) : head_r;
    tail_nxt = push ? ptr_inc(tail_r) : tail_r;
    cnt_nxt  = cnt_r + CW'(push) - CW'(pop);
    // Interrupt state as it stands after this beat
    res.irq_pending = ((cnt_nxt != '0) && ier_nxt[0]) || (ier_nxt[1] && !iir_seen_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ier_r       <= '0;
      fcr_r       <= '0;
      lcr_r       <= LCR_RESET;
      mcr_r       <= '0;
      scr_r       <= '0;
      dll_r       <= '0;
      dlm_r       <= '0;
      psd_r       <= '0;
      iir_seen_r  <= 1'b1;
      head_r      <= '0;
      tail_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        ier_r      <= ier_nxt;
        fcr_r      <= fcr_nxt;
        lcr_r      <= lcr_nxt;
        mcr_r      <= mcr_nxt;
        scr_r      <= scr_nxt;
        dll_r      <= dll_nxt;
        dlm_r      <= dlm_nxt;
        psd_r      <= psd_nxt;
        iir_seen_r <= iir_seen_nxt;
        head_r     <= head_nxt;
        tail_r     <= tail_nxt;
        cnt_r      <= cnt_nxt;
      end
      if (fire) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // Receive store: one write port, registered read of the entry at head.
  // Bypass a byte written into the slot that head points at.
  always_ff @(posedge clk) begin
    if (fire && push) begin
      rx_mem[tail_r] <= q_entry.data;
    end
    if (fire && push && (tail_r == head_nxt)) begin
      head_data_r <= q_entry.data;
    end else begin
      head_data_r <= rx_mem[fire ? head_nxt : head_r];
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(RX_FIFO_DEPTH))
    else $error("rx count above depth");
  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    fire && push |=> cnt_r == $past(cnt_r) + CW'(1))
    else $error("rx count did not advance on push");
  a_fire_shows: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r)
    else $error("executed beat produced no result");
`endif

endmodule

// ===== tb/sv/tb_uart_16550_register_model.sv =====
// Self-checking testbench for the 16550-style UART register file.
// Drives reads, writes and received bytes against a cycle-free register predictor.
// Depends on u16550_pkg and uart_16550_register_model.
`timescale 1ns / 1ps

module tb_uart_16550_register_model;
  import u16550_pkg::*;

  // Action code 3 does nothing in the block; the package leaves it unnamed
  localparam logic [1:0] ACT_NONE = 2'd3;

  localparam int RX_DEPTH   = 16;
  localparam int CLK_HALF   = 6;
  localparam int RAND_BEATS = 1250;
  // Beats left at the end that run with neither side idling
  localparam int CALM_BEATS = 150;
  localparam int DRAIN_AT   = 600;

  typedef enum int {
    SEQ_NOISE,
    SEQ_FIFO,
    SEQ_TX,
    SEQ_DIVISOR,
    SEQ_READBACK
  } seq_kind_t;

  // One row of the directed table; want is used only when typed is set
  typedef struct packed {
    in_item_t  item;
    logic      typed;
    out_item_t want;
  } stim_row_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  uart_16550_register_model #(
    .RX_FIFO_DEPTH(RX_DEPTH)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Register predictor: a private copy of every register and of the receive
  // FIFO, initialized to the reset values.
  // ---------------------------------------------------------------------------
  logic [3:0] ier_q      = '0;
  logic [7:0] fcr_q      = '0;
  logic [7:0] lcr_q      = LCR_RESET;
  logic [3:0] mcr_q      = '0;
  logic [7:0] scr_q      = '0;
  logic [7:0] dll_q      = '0;
  logic [7:0] dlm_q      = '0;
  logic [3:0] psd_q      = '0;
  // Set once the identification register was read after the last transmit
  logic       thr_seen_q = 1'b1;
  logic [7:0] rx_copy [RX_DEPTH];
  int         rx_rd      = 0;
  int         rx_wr      = 0;
  int         rx_level   = 0;

  out_item_t  results_due [$];
  int         mismatches = 0;
  int         beats_sent = 0;
  int         gap_pct    = 20;
  int         stall_pct  = 20;
  logic       calm_tail  = 1'b0;

  // Compose the identification register from the current predictor state
  function automatic logic [7:0] iir_value();
    logic [7:0] v;
    v = '0;
    if (fcr_q[0]) v[7:6] = IIR_FIFO_ON;
    if (rx_level > 0 && ier_q[0]) v[3:0] = IIR_RX_AVAIL;
    else if (ier_q[1] && !thr_seen_q) v[3:0] = IIR_THR_EMPTY;
    else v[3:0] = IIR_NONE;
    return v;
  endfunction

  // Apply one accepted beat to the predictor and return the result it causes
  function automatic out_item_t uart_register_step(input in_item_t it);
    out_item_t  r;
    logic       dlab;
    logic [7:0] iir;
    r    = '0;
    dlab = lcr_q[LCR_DLAB_BIT];
    case (it.action)
      ACT_READ: begin
        case (it.reg_addr)
          REG_DATA: begin
            if (dlab) begin
              r.read_data = dll_q;
            end else if (rx_level > 0) begin
              r.read_data = rx_copy[rx_rd];
              rx_rd       = (rx_rd + 1) % RX_DEPTH;
              rx_level--;
            end
          end
          REG_IER: r.read_data = dlab ? dlm_q : {4'h0, ier_q};
          REG_IIR: begin
            // form the value first, then mark the transmit interrupt as seen
            r.read_data = iir_value();
            thr_seen_q  = 1'b1;
          end
          REG_LCR: r.read_data = lcr_q;
          REG_MCR: r.read_data = {4'h0, mcr_q};
          REG_LSR: begin
            if (!dlab) r.read_data = LSR_TX_IDLE | ((rx_level > 0) ? 8'h01 : 8'h00);
          end
          REG_MSR: r.read_data = '0;
          default: r.read_data = scr_q;
        endcase
      end
      ACT_WRITE: begin
        case (it.reg_addr)
          REG_DATA: begin
            if (dlab) begin
              dll_q = it.write_data;
            end else begin
              thr_seen_q = 1'b0;
              r.tx_valid = 1'b1;
              r.tx_byte  = it.write_data;
            end
          end
          REG_IER: begin
            if (dlab) dlm_q = it.write_data;
            else ier_q = it.write_data[3:0];
          end
          REG_IIR: fcr_q = it.write_data & FCR_MASK;
          REG_LCR: lcr_q = it.write_data;
          REG_MCR: mcr_q = it.write_data[3:0];
          REG_LSR: begin
            if (dlab) psd_q = it.write_data[3:0];
          end
          REG_MSR: ;
          default: scr_q = it.write_data;
        endcase
      end
      ACT_ARRIVE: begin
        // drop the byte and flag it when the FIFO is full
        if (rx_level >= RX_DEPTH) begin
          r.rx_overflow = 1'b1;
        end else begin
          rx_copy[rx_wr] = it.rx_byte;
          rx_wr          = (rx_wr + 1) % RX_DEPTH;
          rx_level++;
        end
      end
      default: ;
    endcase
    iir           = iir_value();
    r.irq_pending = ~iir[0];
    return r;
  endfunction

  function automatic logic [7:0] rnd8();
    return 8'($urandom);
  endfunction

  function automatic out_item_t res(input logic [7:0] rd, input logic txv,
                                    input logic [7:0] txb, input logic irq,
                                    input logic ovf);
    out_item_t r;
    r.read_data   = rd;
    r.tx_valid    = txv;
    r.tx_byte     = txb;
    r.irq_pending = irq;
    r.rx_overflow = ovf;
    return r;
  endfunction

  function automatic stim_row_t beat_row(input logic [1:0] act, input logic [2:0] addr,
                                         input logic [7:0] wd, input logic [7:0] rb,
                                         input logic typed, input out_item_t want);
    stim_row_t s;
    s.item.action     = act;
    s.item.reg_addr   = addr;
    s.item.write_data = wd;
    s.item.rx_byte    = rb;
    s.typed           = typed;
    s.want            = want;
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side: optionally idle for a burst, then hold the beat until accepted.
  // Valid is left high after acceptance so the next beat can follow back to
  // back; the caller drops it when it pauses.
  // ---------------------------------------------------------------------------
  task automatic send_beat(input in_item_t it, input logic typed, input out_item_t want);
    out_item_t predicted;
    if (!calm_tail && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    predicted = uart_register_step(it);
    results_due.push_back(typed ? want : predicted);
    if (it.action != ACT_NONE) beats_sent++;
  endtask

  // Send one beat whose payload byte goes to the field the action uses;
  // fill the unused byte fields with noise
  task automatic put(input logic [1:0] act, input logic [2:0] addr, input logic [7:0] data);
    in_item_t it;
    it.action     = act;
    it.reg_addr   = addr;
    it.write_data = (act == ACT_WRITE) ? data : rnd8();
    it.rx_byte    = (act == ACT_ARRIVE) ? data : rnd8();
    send_beat(it, 1'b0, '0);
  endtask

  // ---------------------------------------------------------------------------
  // Output side: stall in random bursts, with the stall rate re-picked now and
  // then so that long stretches run with no stall at all.
  // ---------------------------------------------------------------------------
  initial begin
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 199) == 0) begin
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 10;
          default: stall_pct = 35;
        endcase
      end
      if (!calm_tail && $urandom_range(0, 99) < stall_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Compare every accepted result beat with the oldest expectation
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (results_due.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual %p", $time, out_item);
        mismatches++;
      end else begin
        want = results_due.pop_front();
        check_field("read_data", want.read_data, out_item.read_data);
        check_field("tx_valid", {7'd0, want.tx_valid}, {7'd0, out_item.tx_valid});
        check_field("tx_byte", want.tx_byte, out_item.tx_byte);
        check_field("irq_pending", {7'd0, want.irq_pending}, {7'd0, out_item.irq_pending});
        check_field("rx_overflow", {7'd0, want.rx_overflow}, {7'd0, out_item.rx_overflow});
      end
    end
  end

  // Guard against a hung handshake
  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus: directed table, a full drain, then random register sequences.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    stim_row_t directed_rows [$];
    seq_kind_t seq;
    logic      first_seq;
    logic      drained_mid;
    int        total;
    int        n;
    int        k;
    logic [2:0] addr;

    first_seq   = 1'b1;
    drained_mid = 1'b0;

    // Hold reset, then release it at a clock edge
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Reset values, empty-FIFO read and the do-nothing action
    directed_rows.push_back(beat_row(ACT_READ, REG_LCR, 8'h00, 8'h00, 1'b1,
                                     res(LCR_RESET, 1'b0, 8'h00, 1'b0, 1'b0)));
    directed_rows.push_back(beat_row(ACT_READ, REG_IIR, 8'hFF, 8'hFF, 1'b1,
                                     res({4'h0, IIR_NONE}, 1'b0, 8'h00, 1'b0, 1'b0)));
    directed_rows.push_back(beat_row(ACT_READ, REG_LSR, 8'h00, 8'h00, 1'b1,
                                     res(LSR_TX_IDLE, 1'b0, 8'h00, 1'b0, 1'b0)));
    directed_rows.push_back(beat_row(ACT_READ, REG_DATA, 8'h00, 8'h00, 1'b1,
                                     res(8'h00, 1'b0, 8'h00, 1'b0, 1'b0)));
    directed_rows.push_back(beat_row(ACT_NONE, REG_SCR, 8'hFF, 8'hFF, 1'b1,
                                     res(8'h00, 1'b0, 8'h00, 1'b0, 1'b0)));
    // Transmit interrupt: raised by a data write, cleared by reading the ident
    directed_rows.push_back(beat_row(ACT_WRITE, REG_IER, 8'hFF, 8'h00, 1'b0, '0));
    directed_rows.push_back(beat_row(ACT_WRITE, REG_DATA, 8'hFF, 8'h00, 1'b1,
                                     res(8'h00, 1'b1, 8'hFF, 1'b1, 1'b0)));
    directed_rows.push_back(beat_row(ACT_READ, REG_IIR, 8'h00, 8'h00, 1'b1,
                                     res({4'h0, IIR_THR_EMPTY}, 1'b0, 8'h00, 1'b0, 1'b0)));
    // FIFO enable bits and receive path with byte extremes
    directed_rows.push_back(beat_row(ACT_WRITE, REG_IIR, 8'hFF, 8'h00, 1'b0, '0));
    directed_rows.push_back(beat_row(ACT_READ, REG_IIR, 8'h00, 8'h00, 1'b0, '0));
    directed_rows.push_back(beat_row(ACT_ARRIVE, REG_DATA, 8'h00, 8'h00, 1'b0, '0));
    directed_rows.push_back(beat_row(ACT_ARRIVE, REG_SCR, 8'hFF, 8'hFF, 1'b0, '0));
    directed_rows.push_back(beat_row(ACT_READ, REG_LSR, 8'h00, 8'h00, 1'b0, '0));
    directed_rows.push_back(beat_row(ACT_READ, REG_DATA, 8'h00, 8'h00, 1'b0, '0));
    directed_rows.push_back(beat_row(ACT_READ, REG_DATA, 8'h00, 8'h00, 1'b0, '0));
    // Loopback and upper modem control bits are dropped
    directed_rows.push_back(beat_row(ACT_WRITE, REG_MCR, 8'hFF, 8'h00, 1'b0, '0));
    directed_rows.push_back(beat_row(ACT_READ, REG_MCR, 8'h00, 8'h00, 1'b0, '0));
    directed_rows.push_back(beat_row(ACT_WRITE, REG_SCR, 8'hFF, 8'h00, 1'b0, '0));
    directed_rows.push_back(beat_row(ACT_READ, REG_SCR, 8'h00, 8'h00, 1'b0, '0));
    // Divisor bank: latches, prescaler, and the banked status read
    directed_rows.push_back(beat_row(ACT_WRITE, REG_LCR, 8'hFF, 8'h00, 1'b0, '0));
    directed_rows.push_back(beat_row(ACT_WRITE, REG_DATA, 8'hFF, 8'h00, 1'b0, '0));
    directed_rows.push_back(beat_row(ACT_WRITE, REG_IER, 8'h5A, 8'h00, 1'b0, '0));
    directed_rows.push_back(beat_row(ACT_WRITE, REG_LSR, 8'hFF, 8'h00, 1'b0, '0));
    directed_rows.push_back(beat_row(ACT_READ, REG_DATA, 8'h00, 8'h00, 1'b0, '0));
    directed_rows.push_back(beat_row(ACT_READ, REG_IER, 8'h00, 8'h00, 1'b0, '0));
    directed_rows.push_back(beat_row(ACT_READ, REG_LSR, 8'h00, 8'h00, 1'b0, '0));
    directed_rows.push_back(beat_row(ACT_READ, REG_MSR, 8'h00, 8'h00, 1'b0, '0));
    directed_rows.push_back(beat_row(ACT_WRITE, REG_LCR, 8'h00, 8'h00, 1'b0, '0));

    foreach (directed_rows[i])
      send_beat(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);

    // Pause the sender until every expected result has come back
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);

    total = beats_sent + RAND_BEATS;
    while (beats_sent < total) begin
      calm_tail = (beats_sent >= total - CALM_BEATS);
      case ($urandom_range(0, 2))
        0: gap_pct = 0;
        1: gap_pct = 10;
        default: gap_pct = 35;
      endcase

      // Drain once more around the middle of the run
      if (!drained_mid && beats_sent >= DRAIN_AT) begin
        drained_mid = 1'b1;
        in_valid <= 1'b0;
        while (results_due.size() != 0) @(posedge clk);
      end

      // Start with a fill that is sure to overflow the receive FIFO
      seq       = first_seq ? SEQ_FIFO : seq_kind_t'($urandom_range(0, 4));
      case (seq)
        SEQ_NOISE: begin
          // fully random beats, do-nothing actions and banked accesses included
          repeat ($urandom_range(1, 8)) send_beat(in_item_t'($urandom), 1'b0, '0);
        end
        SEQ_FIFO: begin
          put(ACT_WRITE, REG_LCR, rnd8() & 8'h7F);
          if ($urandom_range(0, 1)) put(ACT_WRITE, REG_IER, rnd8());
          if ($urandom_range(0, 2) == 0) put(ACT_WRITE, REG_IIR, rnd8());
          n = first_seq ? RX_DEPTH + 3 : $urandom_range(1, RX_DEPTH + 4);
          repeat (n) put(ACT_ARRIVE, 3'($urandom), rnd8());
          k = $urandom_range(0, n + 2);
          repeat (k) begin
            case ($urandom_range(0, 7))
              0: put(ACT_READ, REG_LSR, '0);
              1: put(ACT_READ, REG_IIR, '0);
              2: put(ACT_ARRIVE, 3'($urandom), rnd8());
              default: put(ACT_READ, REG_DATA, '0);
            endcase
          end
        end
        SEQ_TX: begin
          put(ACT_WRITE, REG_LCR, rnd8() & 8'h7F);
          put(ACT_WRITE, REG_IER, rnd8());
          repeat ($urandom_range(1, 3)) begin
            put(ACT_WRITE, REG_DATA, rnd8());
            if ($urandom_range(0, 1)) put(ACT_READ, 3'($urandom), '0);
            put(ACT_READ, REG_IIR, '0);
          end
          if ($urandom_range(0, 1)) put(ACT_READ, REG_IIR, '0);
        end
        SEQ_DIVISOR: begin
          put(ACT_WRITE, REG_LCR, rnd8() | 8'h80);
          put(ACT_WRITE, REG_DATA, rnd8());
          put(ACT_WRITE, REG_IER, rnd8());
          put(ACT_WRITE, REG_LSR, rnd8());
          put(ACT_READ, REG_DATA, '0);
          put(ACT_READ, REG_IER, '0);
          put(ACT_READ, REG_LSR, '0);
          put(ACT_READ, REG_IIR, '0);
          put(ACT_WRITE, REG_MSR, rnd8());
          put(ACT_READ, REG_MSR, '0);
          put(ACT_READ, REG_LCR, '0);
          put(ACT_WRITE, REG_LCR, rnd8() & 8'h7F);
        end
        default: begin
          // write a register and read it straight back
          repeat ($urandom_range(1, 4)) begin
            addr = 3'($urandom_range(1, 7));
            put(ACT_WRITE, addr, rnd8());
            put(ACT_READ, addr, '0);
          end
        end
      endcase
      first_seq = 1'b0;
    end

    // Drop valid, let every result arrive, then let the pipeline settle
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/u16550_pkg.sv
hw/rtl/u16550_front.sv
hw/rtl/u16550_back.sv
hw/rtl/uart_16550_register_model.sv
tb/sv/tb_uart_16550_register_model.sv
